@@ hw/rtl/write_back_store_dirty_lines_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the write-back store core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WRITE_BACK_STORE_DIRTY_LINES_CORE_DEFINES_SVH
`define WRITE_BACK_STORE_DIRTY_LINES_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define WBSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wbsd check failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define WBSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wbsd check failed: next-cycle implication");

`else

`define WBSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define WBSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/wbsd_pkg.sv @@
// ----------------------------------------------------------------------------
// wbsd_pkg
// Types, codes and defaults shared by the write-back store core.
// ----------------------------------------------------------------------------
package wbsd_pkg;

    localparam int ADDR_W      = 12;
    localparam int DATA_W      = 32;
    localparam int LANES       = 4;
    localparam int LANE_W      = 2;
    localparam int MAX_LINES   = 32;
    localparam int LINE_W      = 5;
    localparam int COUNT_W     = 3;
    localparam int LIMIT_W     = 3;

    localparam int STORE_BYTES_DEF   = 4096;
    localparam int LINE_SHIFT_DEF    = 7;
    localparam int NUM_LINES_DEF     = 32;
    localparam int MAX_RUN_LINES_DEF = 4;

    localparam logic [LIMIT_W-1:0] FLUSH_MAX_RESET = 3'd4;

    typedef enum logic [2:0] {
        OP_READ       = 3'd0,
        OP_WRITE      = 3'd1,
        OP_LOAD       = 3'd2,
        OP_FLUSH_SEL  = 3'd3,
        OP_FLUSH_DONE = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } t_size;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_RANGE      = 2'd1,
        STAT_NONE_DIRTY = 2'd2,
        STAT_NO_PENDING = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_ACCESS = 1'b1
    } t_state;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [ADDR_W-1:0] address;
        logic [1:0]        size_code;
        logic [DATA_W-1:0] write_data;
        logic              flush_ok;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic [1:0]         status;
        logic               data_changed;
        logic [LINE_W-1:0]  flush_line;
        logic [COUNT_W-1:0] flush_count;
        logic               any_dirty;
    } t_out_item;

    typedef struct packed {
        logic                 step;
        logic [2:0]           opcode;
        logic                 mark_en;
        logic [MAX_LINES-1:0] mark;
        logic                 flush_ok;
        logic [LIMIT_W-1:0]   limit;
    } t_lines_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic [LINE_W-1:0]  flush_line;
        logic [COUNT_W-1:0] flush_count;
        logic               any_dirty;
    } t_lines_rsp;

endpackage

@@ hw/rtl/wbsd_store.sv @@
// ----------------------------------------------------------------------------
// wbsd_store
// Byte store in four byte lanes, one synchronous memory per lane.
// ----------------------------------------------------------------------------
module wbsd_store #(
    parameter int STORE_BYTES = wbsd_pkg::STORE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [wbsd_pkg::ADDR_W-1:0]   i_rd_addr,
    input  logic [wbsd_pkg::ADDR_W-1:0]   i_addr,
    input  logic [wbsd_pkg::LANES-1:0]    i_len_mask,
    input  logic                          i_wr_en,
    input  logic [wbsd_pkg::DATA_W-1:0]   i_wdata,
    output logic [wbsd_pkg::DATA_W-1:0]   o_rdata,
    output logic                          o_differs
);

    localparam int LANES  = wbsd_pkg::LANES;
    localparam int LANE_W = wbsd_pkg::LANE_W;
    localparam int DEPTH  = STORE_BYTES / LANES;
    localparam int ROW_W  = $clog2(DEPTH);

    logic [ROW_W-1:0]  rd_row  [LANES];
    logic [ROW_W-1:0]  wr_row  [LANES];
    logic [7:0]        wr_byte [LANES];
    logic [LANES-1:0]  wr_en;
    logic [7:0]        rd_byte [LANES];

    // Lane j holds the byte at offset (j - addr[1:0]) mod 4 of the access;
    // lanes below the start lane fall into the next row.
    always_comb begin
        logic [LANE_W-1:0] k;
        for (int j = 0; j < LANES; j++) begin
            k          = LANE_W'(j) - i_addr[LANE_W-1:0];
            rd_row[j]  = ROW_W'(i_rd_addr >> LANE_W)
                       + ROW_W'(LANE_W'(j) < i_rd_addr[LANE_W-1:0]);
            wr_row[j]  = ROW_W'(i_addr >> LANE_W)
                       + ROW_W'(LANE_W'(j) < i_addr[LANE_W-1:0]);
            wr_byte[j] = i_wdata[8*k +: 8];
            wr_en[j]   = i_wr_en && i_len_mask[k];
        end
    end

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        logic [7:0] mem_bank [DEPTH];
        logic [7:0] r_rd_byte;

        always_ff @(posedge i_clk) begin
            if (wr_en[j]) begin
                mem_bank[wr_row[j]] <= wr_byte[j];
            end
            if (i_rd_en) begin
                r_rd_byte <= mem_bank[rd_row[j]];
            end
        end

        assign rd_byte[j] = r_rd_byte;
    end

    // Put the lanes back in access order, zero past the access length.
    always_comb begin
        logic [LANE_W-1:0] lane;
        o_rdata   = '0;
        o_differs = 1'b0;
        for (int k = 0; k < LANES; k++) begin
            lane = i_addr[LANE_W-1:0] + LANE_W'(k);
            if (i_len_mask[k]) begin
                o_rdata[8*k +: 8] = rd_byte[lane];
                if (rd_byte[lane] != i_wdata[8*k +: 8]) begin
                    o_differs = 1'b1;
                end
            end
        end
    end

endmodule

@@ hw/rtl/wbsd_lines.sv @@
// ----------------------------------------------------------------------------
// wbsd_lines
// Dirty-line mask, flush run selection and pending run bookkeeping.
// ----------------------------------------------------------------------------
module wbsd_lines #(
    parameter int NUM_LINES     = wbsd_pkg::NUM_LINES_DEF,
    parameter int MAX_RUN_LINES = wbsd_pkg::MAX_RUN_LINES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_capture,
    input  wbsd_pkg::t_lines_cmd i_cmd,
    output wbsd_pkg::t_lines_rsp o_rsp
);

    localparam int LINE_W  = wbsd_pkg::LINE_W;
    localparam int COUNT_W = wbsd_pkg::COUNT_W;
    localparam int SPAN_A  = (MAX_RUN_LINES < NUM_LINES) ? MAX_RUN_LINES : NUM_LINES;
    localparam int RUN_SPAN = (SPAN_A < 7) ? SPAN_A : 7;

    logic [NUM_LINES-1:0] r_dirty, n_dirty;
    logic [NUM_LINES-1:0] r_pend_run, n_pend_run;
    logic                 r_pend_valid, n_pend_valid;
    logic [LINE_W-1:0]    r_pend_first, n_pend_first;
    logic [COUNT_W-1:0]   r_pend_count, n_pend_count;
    logic [LINE_W-1:0]    r_first;

    logic [NUM_LINES-1:0] merged;
    logic [NUM_LINES-1:0] shifted;
    logic [NUM_LINES-1:0] run;
    logic [LINE_W-1:0]    low_line;
    logic [COUNT_W-1:0]   lim;
    logic [COUNT_W-1:0]   run_cnt;

    // A select first folds an open run back into the mask.
    assign merged = r_dirty | (r_pend_valid ? r_pend_run : '0);

    always_comb begin
        low_line = '0;
        for (int i = NUM_LINES - 1; i >= 0; i--) begin
            if (merged[i]) begin
                low_line = LINE_W'(i);
            end
        end
    end

    always_comb begin
        logic still;
        if (i_cmd.limit == '0) begin
            lim = COUNT_W'(1);
        end else if (32'(i_cmd.limit) > MAX_RUN_LINES) begin
            lim = COUNT_W'(MAX_RUN_LINES);
        end else begin
            lim = i_cmd.limit;
        end
        shifted = merged >> r_first;
        still   = 1'b1;
        run_cnt = '0;
        for (int i = 0; i < RUN_SPAN; i++) begin
            still = still && shifted[i] && (COUNT_W'(i) < lim);
            if (still) begin
                run_cnt = run_cnt + COUNT_W'(1);
            end
        end
        for (int i = 0; i < NUM_LINES; i++) begin
            run[i] = (32'(i) >= 32'(r_first))
                  && (32'(i) < 32'(r_first) + 32'(run_cnt));
        end
    end

    always_comb begin
        n_dirty      = r_dirty;
        n_pend_run   = r_pend_run;
        n_pend_valid = r_pend_valid;
        n_pend_first = r_pend_first;
        n_pend_count = r_pend_count;
        o_rsp        = '0;
        o_rsp.status = wbsd_pkg::STAT_OK;
        case (i_cmd.opcode)
            wbsd_pkg::OP_WRITE: begin
                if (i_cmd.mark_en) begin
                    n_dirty = r_dirty | i_cmd.mark[NUM_LINES-1:0];
                end
            end
            wbsd_pkg::OP_FLUSH_SEL: begin
                n_pend_valid = 1'b0;
                n_pend_run   = '0;
                if (merged == '0) begin
                    n_dirty      = merged;
                    o_rsp.status = wbsd_pkg::STAT_NONE_DIRTY;
                end else begin
                    n_dirty           = merged & ~run;
                    n_pend_run        = run;
                    n_pend_valid      = 1'b1;
                    n_pend_first      = r_first;
                    n_pend_count      = run_cnt;
                    o_rsp.flush_line  = r_first;
                    o_rsp.flush_count = run_cnt;
                end
            end
            wbsd_pkg::OP_FLUSH_DONE: begin
                if (!r_pend_valid) begin
                    o_rsp.status = wbsd_pkg::STAT_NO_PENDING;
                end else begin
                    o_rsp.flush_line  = r_pend_first;
                    o_rsp.flush_count = r_pend_count;
                    if (!i_cmd.flush_ok) begin
                        n_dirty = r_dirty | r_pend_run;
                    end
                    n_pend_run   = '0;
                    n_pend_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
        o_rsp.any_dirty = |n_dirty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty      <= '0;
            r_pend_run   <= '0;
            r_pend_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_dirty      <= n_dirty;
            r_pend_run   <= n_pend_run;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_pend_first <= n_pend_first;
            r_pend_count <= n_pend_count;
        end
        if (i_capture) begin
            r_first <= low_line;
        end
    end

endmodule

@@ hw/rtl/write_back_store_dirty_lines_core.sv @@
// ----------------------------------------------------------------------------
// write_back_store_dirty_lines_core
// Byte store with per-line dirty tracking and flush run selection.
// ----------------------------------------------------------------------------
// In the accept cycle the four byte lanes of the store are read; in the
// access state the read data is compared, merged and written back while the
// result goes into the output register. The single read-modify-write pass
// through the lane memories means the block takes no new item until it has
// finished the last. It stays in the access state while an earlier result
// still sits untaken in the output register, and finishes as soon as that
// result leaves. The store needs no clearing pass: its contents are undefined
// until loaded; the dirty mask, the pending flush run and the output valid
// flag come out of reset cleared, and the flush limit comes out at its default.
// Configuration writes are accepted in any cycle.
// ----------------------------------------------------------------------------
`include "write_back_store_dirty_lines_core_defines.svh"

module write_back_store_dirty_lines_core #(
    parameter int STORE_BYTES   = wbsd_pkg::STORE_BYTES_DEF,
    parameter int LINE_SHIFT    = wbsd_pkg::LINE_SHIFT_DEF,
    parameter int NUM_LINES     = wbsd_pkg::NUM_LINES_DEF,
    parameter int MAX_RUN_LINES = wbsd_pkg::MAX_RUN_LINES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  wbsd_pkg::t_in_item                i_in_data,
    // result output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output wbsd_pkg::t_out_item               o_out_data,
    // flush limit register
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wbsd_pkg::LIMIT_W-1:0]      i_cfg_data
);

    localparam int ADDR_W = wbsd_pkg::ADDR_W;
    localparam int SB_W   = $clog2(STORE_BYTES) + 1;
    // Wide enough for address plus length and for STORE_BYTES itself.
    localparam int SUM_W  = ((SB_W > ADDR_W) ? SB_W : ADDR_W) + 1;

    wbsd_pkg::t_state     r_state, n_state;
    wbsd_pkg::t_in_item   r_item;
    wbsd_pkg::t_out_item  r_out, n_out;
    logic                 r_out_valid;
    logic                 r_in_range;
    logic [wbsd_pkg::LANES-1:0]     r_len_mask;
    logic [wbsd_pkg::MAX_LINES-1:0] r_mark;
    logic [wbsd_pkg::LIMIT_W-1:0]   r_flush_max;

    logic                 in_xfer;
    logic                 step;
    logic                 mem_wr_en;
    logic                 in_range;
    logic [wbsd_pkg::LANES-1:0]     len_mask;
    logic [wbsd_pkg::MAX_LINES-1:0] mark;
    logic [wbsd_pkg::DATA_W-1:0]    store_rdata;
    logic                 store_differs;
    logic                 is_rw;
    wbsd_pkg::t_lines_cmd lines_cmd;
    wbsd_pkg::t_lines_rsp lines_rsp;

    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;

    // ---- decode of the incoming item (accept cycle) ----
    always_comb begin
        logic [SUM_W-1:0] nbytes;
        logic [SUM_W-1:0] first_line;
        logic [SUM_W-1:0] last_line;
        case (i_in_data.size_code)
            wbsd_pkg::SZ_BYTE: begin
                len_mask = 4'b0001;
                nbytes   = SUM_W'(1);
            end
            wbsd_pkg::SZ_HALF: begin
                len_mask = 4'b0011;
                nbytes   = SUM_W'(2);
            end
            wbsd_pkg::SZ_WORD: begin
                len_mask = 4'b1111;
                nbytes   = SUM_W'(4);
            end
            default: begin
                len_mask = 4'b0000;
                nbytes   = '0;
            end
        endcase
        // A bad size code leaves nbytes at zero and is caught here too.
        in_range = (nbytes != '0)
                && (SUM_W'(i_in_data.address) + nbytes <= SUM_W'(STORE_BYTES));
        first_line = SUM_W'(i_in_data.address) >> LINE_SHIFT;
        last_line  = (SUM_W'(i_in_data.address) + nbytes - SUM_W'(1)) >> LINE_SHIFT;
        // An access spans at most two lines, so mark the first and the last.
        for (int l = 0; l < wbsd_pkg::MAX_LINES; l++) begin
            mark[l] = (l < NUM_LINES)
                   && ((first_line == SUM_W'(l)) || (last_line == SUM_W'(l)));
        end
    end

    // ---- state machine: next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            wbsd_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = wbsd_pkg::S_ACCESS;
                end
            end
            wbsd_pkg::S_ACCESS: begin
                if (step) begin
                    n_state = wbsd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wbsd_pkg::S_IDLE;
            end
        endcase
    end

    // ---- state machine: outputs ----
    // Finish the item only when the output register is free or draining.
    always_comb begin
        o_in_ready = 1'b0;
        step       = 1'b0;
        case (r_state)
            wbsd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
            end
            wbsd_pkg::S_ACCESS: begin
                step = !r_out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    assign is_rw = (r_item.opcode == wbsd_pkg::OP_READ)
                || (r_item.opcode == wbsd_pkg::OP_WRITE)
                || (r_item.opcode == wbsd_pkg::OP_LOAD);

    // Write back on the finishing edge; an unchanged write rewrites equal bytes.
    assign mem_wr_en = step && r_in_range
                    && ((r_item.opcode == wbsd_pkg::OP_WRITE)
                     || (r_item.opcode == wbsd_pkg::OP_LOAD));

    wbsd_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_en    (in_xfer),
        .i_rd_addr  (i_in_data.address),
        .i_addr     (r_item.address),
        .i_len_mask (r_len_mask),
        .i_wr_en    (mem_wr_en),
        .i_wdata    (r_item.write_data),
        .o_rdata    (store_rdata),
        .o_differs  (store_differs)
    );

    always_comb begin
        lines_cmd          = '0;
        lines_cmd.step     = step;
        lines_cmd.opcode   = r_item.opcode;
        lines_cmd.mark_en  = r_in_range && store_differs;
        lines_cmd.mark     = r_mark;
        lines_cmd.flush_ok = r_item.flush_ok;
        lines_cmd.limit    = r_flush_max;
    end

    wbsd_lines #(
        .NUM_LINES     (NUM_LINES),
        .MAX_RUN_LINES (MAX_RUN_LINES)
    ) u_lines (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_capture (in_xfer),
        .i_cmd     (lines_cmd),
        .o_rsp     (lines_rsp)
    );

    // ---- result assembly ----
    always_comb begin
        n_out             = '0;
        n_out.status      = lines_rsp.status;
        n_out.flush_line  = lines_rsp.flush_line;
        n_out.flush_count = lines_rsp.flush_count;
        n_out.any_dirty   = lines_rsp.any_dirty;
        if (is_rw) begin
            if (!r_in_range) begin
                n_out.status = wbsd_pkg::STAT_RANGE;
            end else if (r_item.opcode == wbsd_pkg::OP_READ) begin
                n_out.read_data = store_rdata;
            end else if (r_item.opcode == wbsd_pkg::OP_WRITE) begin
                n_out.data_changed = store_differs;
            end
        end
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wbsd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_flush_max <= wbsd_pkg::FLUSH_MAX_RESET;
        end else begin
            r_state <= n_state;
            // Load on finish, drop once the result transfer completes.
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_flush_max <= i_cfg_data;
            end
        end
    end

    // Hold the item for the write-back cycle.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item     <= i_in_data;
            r_in_range <= in_range;
            r_len_mask <= len_mask;
            r_mark     <= mark;
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---- checks ----
    `WBSD_ASSERT_IMPLY(a_wr_only_in_access, i_clk, i_rst_n, mem_wr_en, r_state == wbsd_pkg::S_ACCESS && r_in_range)
    `WBSD_ASSERT_NEXT(a_accept_enters_access, i_clk, i_rst_n, in_xfer, r_state == wbsd_pkg::S_ACCESS)
    `WBSD_ASSERT_NEXT(a_stall_holds_item, i_clk, i_rst_n, r_state == wbsd_pkg::S_ACCESS && r_out_valid && !i_out_ready, r_state == wbsd_pkg::S_ACCESS && $stable(r_item))
    `WBSD_ASSERT_IMPLY(a_range_reads_zero, i_clk, i_rst_n, r_out_valid && r_out.status == wbsd_pkg::STAT_RANGE, r_out.read_data == '0 && !r_out.data_changed)

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: write-back store core bench
// Drives reads, writes, loads and flush commands into the core through its
// valid/ready item channel. A local copy of the store, the dirty mask and the
// pending flush run predicts every result, and each result transfer is
// compared field by field. The flush limit register is swept over its full
// code range between phases, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    // Opcodes and size codes outside the defined set
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam logic [1:0] SZ_BAD      = 2'd3;

    localparam int PHASE_ITEMS = 88;
    localparam int HOLD_CYCLES = 80;

    localparam int STORE_BYTES = wbsd_pkg::STORE_BYTES_DEF;
    localparam int LINE_SHIFT  = wbsd_pkg::LINE_SHIFT_DEF;
    localparam int NUM_LINES   = wbsd_pkg::NUM_LINES_DEF;
    localparam int MAX_RUN     = wbsd_pkg::MAX_RUN_LINES_DEF;
    localparam int ADDR_W      = wbsd_pkg::ADDR_W;
    localparam int DATA_W      = wbsd_pkg::DATA_W;
    localparam int LINE_W      = wbsd_pkg::LINE_W;
    localparam int COUNT_W     = wbsd_pkg::COUNT_W;
    localparam int LIMIT_W     = wbsd_pkg::LIMIT_W;
    localparam int MAX_LINES   = wbsd_pkg::MAX_LINES;

    typedef struct {
        wbsd_pkg::t_in_item  item;
        bit                  typed;
        wbsd_pkg::t_out_item want;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    wbsd_pkg::t_in_item   i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    wbsd_pkg::t_out_item  o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [LIMIT_W-1:0]   i_cfg_data;

    // Predictor state: byte image, dirty mask, open flush run, limit
    logic [7:0]           mem_image [0:STORE_BYTES-1];
    bit                   byte_known [0:STORE_BYTES-1];
    logic [MAX_LINES-1:0] dirty_mask;
    logic [MAX_LINES-1:0] run_mask;
    bit                   run_pending;
    int                   run_first;
    int                   run_count;
    logic [LIMIT_W-1:0]   flush_limit;

    wbsd_pkg::t_out_item  store_responses_q [$];
    logic [ADDR_W-1:0]    loaded_addrs [$];
    t_dir_row             dir_rows [$];
    int                   mismatch_count;
    bit                   sender_burst;
    bit                   receiver_burst;

    logic [LIMIT_W-1:0]   limit_plan [8] = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6};

    write_back_store_dirty_lines_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int size_bytes(input logic [1:0] sz);
        case (sz)
            wbsd_pkg::SZ_BYTE: return 1;
            wbsd_pkg::SZ_HALF: return 2;
            default:           return 4;
        endcase
    endfunction

    // Advance the predictor by one item and return the result it causes.
    function automatic wbsd_pkg::t_out_item model_store_access(input wbsd_pkg::t_in_item it);
        wbsd_pkg::t_out_item r;
        int        nb;
        int        lim;
        int        first;
        int        n;
        int        k;
        int        l;
        bit        in_range;
        bit        differs;
        logic [7:0] b;
        r = '0;
        nb = size_bytes(it.size_code);
        in_range = (it.size_code != SZ_BAD) && (int'(it.address) + nb <= STORE_BYTES);
        case (it.opcode)
            wbsd_pkg::OP_READ, wbsd_pkg::OP_WRITE, wbsd_pkg::OP_LOAD: begin
                if (!in_range) begin
                    r.status = wbsd_pkg::STAT_RANGE;
                end else if (it.opcode == wbsd_pkg::OP_READ) begin
                    for (k = 0; k < nb; k++)
                        r.read_data[8*k +: 8] = mem_image[int'(it.address) + k];
                end else begin
                    differs = 1'b0;
                    for (k = 0; k < nb; k++) begin
                        b = it.write_data[8*k +: 8];
                        if (mem_image[int'(it.address) + k] !== b)
                            differs = 1'b1;
                        mem_image[int'(it.address) + k] = b;
                        byte_known[int'(it.address) + k] = 1'b1;
                    end
                    // Only a real change dirties, and every touched line is marked
                    if (it.opcode == wbsd_pkg::OP_WRITE && differs) begin
                        for (l = int'(it.address) >> LINE_SHIFT;
                             l <= (int'(it.address) + nb - 1) >> LINE_SHIFT; l++)
                            if (l < NUM_LINES)
                                dirty_mask[l] = 1'b1;
                        r.data_changed = 1'b1;
                    end
                end
            end
            wbsd_pkg::OP_FLUSH_SEL: begin
                lim = int'(flush_limit);
                if (lim == 0)
                    lim = 1;
                if (lim > MAX_RUN)
                    lim = MAX_RUN;
                // An open run counts as failed before the next one is picked
                if (run_pending) begin
                    dirty_mask |= run_mask;
                    run_mask = '0;
                    run_pending = 1'b0;
                end
                if (dirty_mask == '0) begin
                    r.status = wbsd_pkg::STAT_NONE_DIRTY;
                end else begin
                    first = 0;
                    while (!dirty_mask[first])
                        first++;
                    n = 1;
                    while (first + n < NUM_LINES && n < lim && dirty_mask[first + n])
                        n++;
                    run_mask = '0;
                    for (l = first; l < first + n; l++)
                        run_mask[l] = 1'b1;
                    dirty_mask &= ~run_mask;
                    run_pending = 1'b1;
                    run_first = first;
                    run_count = n;
                    r.flush_line = LINE_W'(first);
                    r.flush_count = COUNT_W'(n);
                end
            end
            wbsd_pkg::OP_FLUSH_DONE: begin
                if (!run_pending) begin
                    r.status = wbsd_pkg::STAT_NO_PENDING;
                end else begin
                    r.flush_line = LINE_W'(run_first);
                    r.flush_count = COUNT_W'(run_count);
                    if (!it.flush_ok)
                        dirty_mask |= run_mask;
                    run_mask = '0;
                    run_pending = 1'b0;
                end
            end
            default: ;
        endcase
        r.any_dirty = (dirty_mask != '0);
        return r;
    endfunction

    // Favor line boundaries and the top of the store for loads.
    function automatic logic [ADDR_W-1:0] spread_address();
        int pick;
        int a;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            a = $urandom_range(1, NUM_LINES - 1) * (1 << LINE_SHIFT) - 4
                + $urandom_range(0, 7);
        else if (pick == 4)
            a = $urandom_range(STORE_BYTES - 8, STORE_BYTES - 1);
        else
            a = $urandom_range(0, STORE_BYTES - 1);
        return a[ADDR_W-1:0];
    endfunction

    // Draw one random item; reads and writes only ever touch loaded bytes.
    function automatic wbsd_pkg::t_in_item random_item();
        wbsd_pkg::t_in_item it;
        int       roll;
        int       base;
        int       nb;
        int       k;
        bit       all_known;
        bit       same_data;
        bit       access;
        it.opcode     = wbsd_pkg::OP_READ;
        it.address    = ADDR_W'($urandom);
        it.size_code  = 2'($urandom_range(0, 2));
        it.write_data = $urandom;
        it.flush_ok   = 1'($urandom_range(0, 1));
        same_data = 1'b0;
        access = 1'b0;
        roll = $urandom_range(0, 99);
        // Close an open run on one draw in four, on top of the normal mix
        if (run_pending && $urandom_range(0, 3) == 0)
            roll = 80;
        if (roll < 20) begin
            it.opcode = wbsd_pkg::OP_READ;
            access = 1'b1;
        end else if (roll < 50) begin
            it.opcode = wbsd_pkg::OP_WRITE;
            access = 1'b1;
        end else if (roll < 62) begin
            it.opcode = wbsd_pkg::OP_LOAD;
            it.address = spread_address();
        end else if (roll < 74) begin
            it.opcode = wbsd_pkg::OP_FLUSH_SEL;
        end else if (roll < 86) begin
            it.opcode = wbsd_pkg::OP_FLUSH_DONE;
        end else if (roll < 90) begin
            it.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end else if (roll < 96) begin
            case ($urandom_range(0, 2))
                0:       it.opcode = wbsd_pkg::OP_READ;
                1:       it.opcode = wbsd_pkg::OP_WRITE;
                default: it.opcode = wbsd_pkg::OP_LOAD;
            endcase
            if ($urandom_range(0, 1)) begin
                it.size_code = SZ_BAD;
            end else begin
                it.size_code = wbsd_pkg::SZ_WORD;
                it.address = ADDR_W'($urandom_range(STORE_BYTES - 3, STORE_BYTES - 1));
            end
        end else begin
            it.opcode = wbsd_pkg::OP_WRITE;
            access = 1'b1;
            same_data = 1'b1;
        end

        if (access) begin
            if (loaded_addrs.size() == 0) begin
                it.opcode = wbsd_pkg::OP_LOAD;
                it.address = spread_address();
            end else begin
                base = int'(loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)])
                       + $urandom_range(0, 3);
                if (base > STORE_BYTES - 1)
                    base = STORE_BYTES - 1;
                it.address = base[ADDR_W-1:0];
                nb = size_bytes(it.size_code);
                if (base + nb <= STORE_BYTES) begin
                    all_known = 1'b1;
                    for (k = 0; k < nb; k++)
                        if (!byte_known[base + k])
                            all_known = 1'b0;
                    if (!all_known)
                        it.opcode = wbsd_pkg::OP_LOAD;
                    else if (same_data)
                        for (k = 0; k < nb; k++)
                            it.write_data[8*k +: 8] = mem_image[base + k];
                end
            end
        end
        return it;
    endfunction

    function automatic wbsd_pkg::t_out_item outcome(input logic [DATA_W-1:0] rd,
                                                    input logic [1:0] st,
                                                    input int fl, input int fc,
                                                    input logic ad);
        wbsd_pkg::t_out_item r;
        r = '0;
        r.read_data = rd;
        r.status = st;
        r.flush_line = LINE_W'(fl);
        r.flush_count = COUNT_W'(fc);
        r.any_dirty = ad;
        return r;
    endfunction

    task automatic add_row(input logic [2:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [1:0] sz, input logic [DATA_W-1:0] wd, input logic ok,
                           input bit typed, input wbsd_pkg::t_out_item want);
        t_dir_row row;
        row.item.opcode = op;
        row.item.address = addr;
        row.item.size_code = sz;
        row.item.write_data = wd;
        row.item.flush_ok = ok;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
        mismatch_count++;
    endtask

    // Predict, queue the result, then offer the item until it transfers.
    // Return at a falling edge, after the idle gap if one was drawn.
    task automatic issue_item(input wbsd_pkg::t_in_item it, input bit typed,
                              input wbsd_pkg::t_out_item want, input int gap);
        wbsd_pkg::t_out_item predicted;
        predicted = model_store_access(it);
        store_responses_q.push_back(typed ? want : predicted);
        if (it.opcode == wbsd_pkg::OP_LOAD && it.size_code != SZ_BAD
            && int'(it.address) + size_bytes(it.size_code) <= STORE_BYTES)
            loaded_addrs.push_back(it.address);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Write the flush limit; call only with nothing in flight.
    task automatic write_flush_limit(input logic [LIMIT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        flush_limit = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Main sequence: reset, directed table, then random phases per limit.
    initial begin
        int                 phase;
        int                 n;
        int                 gap;
        wbsd_pkg::t_in_item it;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        mismatch_count = 0;
        sender_burst = 1'b0;
        foreach (mem_image[idx]) begin
            mem_image[idx] = '0;
            byte_known[idx] = 1'b0;
        end
        dirty_mask = '0;
        run_mask = '0;
        run_pending = 1'b0;
        run_first = 0;
        run_count = 0;
        flush_limit = wbsd_pkg::FLUSH_MAX_RESET;

        // Hold reset, then release it on a falling edge
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty store: flush commands with nothing to do, range errors, spare opcodes
        add_row(wbsd_pkg::OP_FLUSH_SEL, 12'h000, wbsd_pkg::SZ_BYTE, 32'h0, 1'b0, 1'b1,
                outcome(32'h0, wbsd_pkg::STAT_NONE_DIRTY, 0, 0, 1'b0));
        add_row(wbsd_pkg::OP_FLUSH_DONE, 12'h000, wbsd_pkg::SZ_BYTE, 32'h0, 1'b1, 1'b1,
                outcome(32'h0, wbsd_pkg::STAT_NO_PENDING, 0, 0, 1'b0));
        add_row(wbsd_pkg::OP_READ, 12'hfff, wbsd_pkg::SZ_WORD, 32'h0, 1'b0, 1'b1,
                outcome(32'h0, wbsd_pkg::STAT_RANGE, 0, 0, 1'b0));
        add_row(wbsd_pkg::OP_WRITE, 12'hffe, wbsd_pkg::SZ_WORD, 32'hffff_ffff, 1'b1, 1'b1,
                outcome(32'h0, wbsd_pkg::STAT_RANGE, 0, 0, 1'b0));
        add_row(wbsd_pkg::OP_LOAD, 12'hfff, wbsd_pkg::SZ_HALF, 32'hffff_ffff, 1'b0, 1'b1,
                outcome(32'h0, wbsd_pkg::STAT_RANGE, 0, 0, 1'b0));
        add_row(wbsd_pkg::OP_READ, 12'h000, SZ_BAD, 32'h0, 1'b0, 1'b1,
                outcome(32'h0, wbsd_pkg::STAT_RANGE, 0, 0, 1'b0));
        add_row(OP_SPARE_LO, 12'hfff, SZ_BAD, 32'hffff_ffff, 1'b1, 1'b1,
                outcome(32'h0, wbsd_pkg::STAT_OK, 0, 0, 1'b0));
        add_row(OP_SPARE_HI, 12'h000, wbsd_pkg::SZ_BYTE, 32'h0, 1'b0, 1'b1,
                outcome(32'h0, wbsd_pkg::STAT_OK, 0, 0, 1'b0));
        // Fill both ends without dirtying, then read back
        add_row(wbsd_pkg::OP_LOAD, 12'h000, wbsd_pkg::SZ_WORD, 32'h0, 1'b0, 1'b1,
                outcome(32'h0, wbsd_pkg::STAT_OK, 0, 0, 1'b0));
        add_row(wbsd_pkg::OP_LOAD, 12'hffc, wbsd_pkg::SZ_WORD, 32'hffff_ffff, 1'b0, 1'b1,
                outcome(32'h0, wbsd_pkg::STAT_OK, 0, 0, 1'b0));
        add_row(wbsd_pkg::OP_READ, 12'hffc, wbsd_pkg::SZ_WORD, 32'h0, 1'b0, 1'b1,
                outcome(32'hffff_ffff, wbsd_pkg::STAT_OK, 0, 0, 1'b0));
        add_row(wbsd_pkg::OP_READ, 12'hfff, wbsd_pkg::SZ_BYTE, 32'h0, 1'b0, 1'b1,
                outcome(32'h0000_00ff, wbsd_pkg::STAT_OK, 0, 0, 1'b0));
        add_row(wbsd_pkg::OP_READ, 12'h000, wbsd_pkg::SZ_HALF, 32'h0, 1'b0, 1'b1,
                outcome(32'h0, wbsd_pkg::STAT_OK, 0, 0, 1'b0));
        // Word across the line 0/1 boundary: load, change, rewrite unchanged; then dirty the top byte
        add_row(wbsd_pkg::OP_LOAD, 12'h07e, wbsd_pkg::SZ_WORD, 32'ha5a5_a5a5, 1'b0, 1'b0, '0);
        add_row(wbsd_pkg::OP_WRITE, 12'h07e, wbsd_pkg::SZ_WORD, 32'h5a5a_5a5a, 1'b0, 1'b0, '0);
        add_row(wbsd_pkg::OP_WRITE, 12'h07e, wbsd_pkg::SZ_WORD, 32'h5a5a_5a5a, 1'b0, 1'b0, '0);
        add_row(wbsd_pkg::OP_WRITE, 12'hfff, wbsd_pkg::SZ_BYTE, 32'h0000_0000, 1'b0, 1'b0, '0);
        add_row(wbsd_pkg::OP_READ, 12'h07e, wbsd_pkg::SZ_WORD, 32'h0, 1'b0, 1'b0, '0);
        add_row(wbsd_pkg::OP_WRITE, 12'h000, wbsd_pkg::SZ_BYTE, 32'h0, 1'b0, 1'b0, '0);
        // Flush: select, reselect while open, fail, succeed, drain the last line
        add_row(wbsd_pkg::OP_FLUSH_SEL, 12'h000, wbsd_pkg::SZ_BYTE, 32'h0, 1'b0, 1'b0, '0);
        add_row(wbsd_pkg::OP_FLUSH_SEL, 12'h000, wbsd_pkg::SZ_BYTE, 32'h0, 1'b0, 1'b0, '0);
        add_row(wbsd_pkg::OP_FLUSH_DONE, 12'h000, wbsd_pkg::SZ_BYTE, 32'h0, 1'b0, 1'b0, '0);
        add_row(wbsd_pkg::OP_FLUSH_SEL, 12'h000, wbsd_pkg::SZ_BYTE, 32'h0, 1'b0, 1'b0, '0);
        add_row(wbsd_pkg::OP_FLUSH_DONE, 12'h000, wbsd_pkg::SZ_BYTE, 32'h0, 1'b1, 1'b0, '0);
        add_row(wbsd_pkg::OP_FLUSH_SEL, 12'h000, wbsd_pkg::SZ_BYTE, 32'h0, 1'b0, 1'b0, '0);
        add_row(wbsd_pkg::OP_FLUSH_DONE, 12'h000, wbsd_pkg::SZ_BYTE, 32'h0, 1'b1, 1'b0, '0);
        add_row(wbsd_pkg::OP_FLUSH_DONE, 12'h000, wbsd_pkg::SZ_BYTE, 32'h0, 1'b1, 1'b1,
                outcome(32'h0, wbsd_pkg::STAT_NO_PENDING, 0, 0, 1'b0));

        foreach (dir_rows[row_idx])
            issue_item(dir_rows[row_idx].item, dir_rows[row_idx].typed,
                       dir_rows[row_idx].want, $urandom_range(0, 16));

        for (phase = 0; phase < 8; phase++) begin
            // Drop valid and drain before touching the limit register
            i_in_valid <= 1'b0;
            while (store_responses_q.size() != 0)
                @(negedge i_clk);
            write_flush_limit(limit_plan[phase]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Switch between back-to-back stretches and idling stretches
                if (n % 30 == 0)
                    sender_burst = ($urandom_range(0, 3) == 0);
                gap = sender_burst ? 0 : $urandom_range(0, 16);
                it = random_item();
                issue_item(it, 1'b0, '0, gap);
            end
        end

        // Drain, then keep the clock running so that stray results can show
        i_in_valid <= 1'b0;
        while (store_responses_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result receiver: random stall per result, two long hold-offs that
    // let the core fill up and push back on the item channel.
    initial begin
        int gap;
        int taken;
        i_out_ready = 1'b0;
        taken = 0;
        receiver_burst = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (taken % 40 == 0)
                receiver_burst = ($urandom_range(0, 3) == 0);
            if (taken == 150 || taken == 500)
                gap = HOLD_CYCLES;
            else if (receiver_burst)
                gap = 0;
            else
                gap = $urandom_range(0, 16);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid)
                @(posedge i_clk);
            taken++;
            @(negedge i_clk);
        end
    end

    // Result checker: compare each transfer with the oldest prediction
    always @(posedge i_clk) begin
        wbsd_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (store_responses_q.size() == 0) begin
                report_mismatch("result with nothing expected", o_out_data.read_data, '0);
            end else begin
                want = store_responses_q.pop_front();
                if (o_out_data.read_data !== want.read_data)
                    report_mismatch("read_data", o_out_data.read_data, want.read_data);
                if (o_out_data.status !== want.status)
                    report_mismatch("status", 32'(o_out_data.status), 32'(want.status));
                if (o_out_data.data_changed !== want.data_changed)
                    report_mismatch("data_changed", 32'(o_out_data.data_changed),
                                    32'(want.data_changed));
                if (o_out_data.flush_line !== want.flush_line)
                    report_mismatch("flush_line", 32'(o_out_data.flush_line),
                                    32'(want.flush_line));
                if (o_out_data.flush_count !== want.flush_count)
                    report_mismatch("flush_count", 32'(o_out_data.flush_count),
                                    32'(want.flush_count));
                if (o_out_data.any_dirty !== want.any_dirty)
                    report_mismatch("any_dirty", 32'(o_out_data.any_dirty),
                                    32'(want.any_dirty));
            end
        end
    end

    // Watchdog: end a hung run
    initial begin
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule
